// ----- sv/frame_ring_buffer_defines.svh -----
// ----------------------------------------------------------------------------
// frame_ring_buffer_defines
// Assertion macros used by the frame_ring_buffer top module.
// ----------------------------------------------------------------------------
`ifndef FRAME_RING_BUFFER_DEFINES_SVH
`define FRAME_RING_BUFFER_DEFINES_SVH
`ifndef SYNTH
`define FRB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame_ring_buffer: same-cycle check failed");
`define FRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame_ring_buffer: next-cycle check failed");
`else
`define FRB_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define FRB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- sv/frb_pkg.sv -----
// ----------------------------------------------------------------------------
// frb_pkg
// Types and constants shared by the frame ring buffer modules.
// ----------------------------------------------------------------------------
package frb_pkg;

   localparam int DATA_W      = 8;
   localparam int LEN_W       = 7;
   localparam int COUNT_REG_W = 4;
   localparam int CSR_W       = 7;

   localparam logic [LEN_W-1:0]       FRAME_SIZE_RESET  = 7'd64;
   localparam logic [COUNT_REG_W-1:0] FRAME_COUNT_RESET = 4'd8;
   localparam logic [LEN_W-1:0]       MIN_FRAME_COUNT   = 7'd2;

   typedef enum logic {
      CSR_FRAME_SIZE  = 1'b0,
      CSR_FRAME_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_READ  = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_EMPTY      = 2'd1,
      STATUS_BAD_LENGTH = 2'd2
   } status_type;

   typedef enum logic {
      CTRL_IDLE = 1'b0,
      CTRL_READ = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      logic              req_type;
      logic [DATA_W-1:0] data_byte;
      logic [LEN_W-1:0]  read_length;
   } req_payload_type;

   typedef struct packed {
      status_type        status;
      logic [DATA_W-1:0] out_byte;
      logic              last;
   } rsp_payload_type;

   typedef struct packed {
      logic       write_byte;
      logic       read_first;
      logic       read_next;
      logic       advance_read;
      logic       load_out;
      logic       out_data;
      status_type out_status;
      logic       out_last;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic req_is_read;
      logic ring_empty;
      logic length_bad;
      logic length_one;
      logic read_last;
   } dp_status_type;

endpackage

// ----- sv/frame_ring_buffer.sv -----
// ----------------------------------------------------------------------------
// frame_ring_buffer
// Ring of frame buffers fed one byte per write and drained one frame per read.
// ----------------------------------------------------------------------------
//   channel  dir  handshake              payload
//   req_     in   req_valid / req_stall  req_payload_type
//   rsp_     out  rsp_valid / rsp_stall  rsp_payload_type
//   csr_     in   csr_write_en           csr_index, csr_wdata
//
// A write, an empty read and a bad-length read each give a single result.
// A frame read of N bytes gives N results, one byte per cycle from the
// single read port of the frame store while the result is not stalled.
// Reset clears the frame pointers, the fill position and the result valid flag,
// and restores the configuration; the frame store is not cleared.
// A stalled result holds the output register and pauses the frame read.
// ----------------------------------------------------------------------------
`include "frame_ring_buffer_defines.svh"

module frame_ring_buffer #(
   parameter int MAX_FRAME_BYTES = 64,
   parameter int MAX_FRAMES      = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_en,
   input  logic                     csr_index,
   input  logic [frb_pkg::CSR_W-1:0] csr_wdata,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  frb_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output frb_pkg::rsp_payload_type rsp_payload
);
   import frb_pkg::*;

   cmd_type       cmd;
   dp_status_type dp_status;

   frb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   frb_datapath #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
      .MAX_FRAMES      (MAX_FRAMES)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .cmd          (cmd),
      .dp_status    (dp_status)
   );

   // Every accepted request places its first result in the output register.
   `FRB_ASSERT_NEXT(a_accept_gives_result, clock, reset, req_valid && !req_stall, rsp_valid)
   `FRB_ASSERT_IMPLY(a_advance_on_last, clock, reset, cmd.advance_read, cmd.load_out && cmd.out_last && cmd.out_data)
   `FRB_ASSERT_IMPLY(a_status_single, clock, reset, rsp_valid && rsp_payload.status != STATUS_OK, rsp_payload.last && rsp_payload.out_byte == '0)
   `FRB_ASSERT_IMPLY(a_no_accept_in_read, clock, reset, cmd.read_next, req_stall)

endmodule

// ----- sv/frb_ctrl.sv -----
// ----------------------------------------------------------------------------
// frb_ctrl
// Controller: decodes each request and sequences the bytes of a frame read.
// ----------------------------------------------------------------------------
module frb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  frb_pkg::dp_status_type dp_status,
   output frb_pkg::cmd_type      cmd
);
   import frb_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_stall      = 1'b1;
      cmd            = '0;
      cmd.out_status = STATUS_OK;
      case (state_ff)
         CTRL_IDLE: begin
            req_stall = !dp_status.out_free;
            if (req_valid && dp_status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_last = 1'b1;
               if (!dp_status.req_is_read) begin
                  cmd.write_byte = 1'b1;
               end else if (dp_status.ring_empty) begin
                  cmd.out_status = STATUS_EMPTY;
               end else if (dp_status.length_bad) begin
                  cmd.out_status = STATUS_BAD_LENGTH;
               end else begin
                  cmd.read_first = 1'b1;
                  cmd.out_data   = 1'b1;
                  cmd.out_last   = dp_status.length_one;
                  if (dp_status.length_one) begin
                     cmd.advance_read = 1'b1;
                  end else begin
                     state_in = CTRL_READ;
                  end
               end
            end
         end
         CTRL_READ: begin
            if (dp_status.out_free) begin
               cmd.read_next = 1'b1;
               cmd.load_out  = 1'b1;
               cmd.out_data  = 1'b1;
               cmd.out_last  = dp_status.read_last;
               if (dp_status.read_last) begin
                  cmd.advance_read = 1'b1;
                  state_in         = CTRL_IDLE;
               end
            end
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

endmodule

// ----- sv/frb_datapath.sv -----
// ----------------------------------------------------------------------------
// frb_datapath
// Datapath: configuration registers, frame pointers, frame store and the
// result register.
// ----------------------------------------------------------------------------
module frb_datapath #(
   parameter int MAX_FRAME_BYTES = 64,
   parameter int MAX_FRAMES      = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_en,
   input  logic                     csr_index,
   input  logic [frb_pkg::CSR_W-1:0] csr_wdata,
   input  frb_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output frb_pkg::rsp_payload_type rsp_payload,
   input  frb_pkg::cmd_type         cmd,
   output frb_pkg::dp_status_type   dp_status
);
   import frb_pkg::*;

   localparam int FRAME_W = $clog2(MAX_FRAMES);
   localparam int POS_W   = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
   localparam int DEPTH   = MAX_FRAMES * MAX_FRAME_BYTES;
   localparam int ADDR_W  = $clog2(DEPTH);

   localparam logic [LEN_W-1:0]  MAX_SIZE     = LEN_W'(MAX_FRAME_BYTES);
   localparam logic [LEN_W-1:0]  MAX_COUNT    = LEN_W'(MAX_FRAMES);
   localparam logic [ADDR_W-1:0] FRAME_STRIDE = ADDR_W'(MAX_FRAME_BYTES);

   logic [LEN_W-1:0]       frame_size_ff,  frame_size_in;
   logic [COUNT_REG_W-1:0] frame_count_ff, frame_count_in;
   logic [FRAME_W-1:0]     write_frame_ff, write_frame_in;
   logic [FRAME_W-1:0]     read_frame_ff,  read_frame_in;
   logic [POS_W-1:0]       fill_pos_ff,    fill_pos_in;
   logic [LEN_W-1:0]       length_ff,      length_in;
   logic [LEN_W-1:0]       seq_count_ff,   seq_count_in;
   logic                   rsp_valid_ff,   rsp_valid_in;
   status_type             rsp_status_ff,  rsp_status_in;
   logic                   rsp_last_ff,    rsp_last_in;
   logic                   rsp_data_ff,    rsp_data_in;
   logic [DATA_W-1:0]      rd_data_ff;

   logic [DATA_W-1:0] frame_mem [DEPTH];

   logic [LEN_W-1:0]  eff_size;
   logic [LEN_W-1:0]  eff_count;
   logic [LEN_W-1:0]  last_frame;
   logic              fill_done;
   logic [POS_W-1:0]  rd_pos;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic              rd_en;

   function automatic logic [FRAME_W-1:0] next_frame(input logic [FRAME_W-1:0] f,
                                                     input logic [LEN_W-1:0]   last);
      logic [FRAME_W-1:0] result;
      if (LEN_W'(f) >= last) begin
         result = '0;
      end else begin
         result = f + FRAME_W'(1);
      end
      return result;
   endfunction

   always_comb begin
      if (frame_size_ff == '0) begin
         eff_size = LEN_W'(1);
      end else if (frame_size_ff > MAX_SIZE) begin
         eff_size = MAX_SIZE;
      end else begin
         eff_size = frame_size_ff;
      end
      if (LEN_W'(frame_count_ff) < MIN_FRAME_COUNT) begin
         eff_count = MIN_FRAME_COUNT;
      end else if (LEN_W'(frame_count_ff) > MAX_COUNT) begin
         eff_count = MAX_COUNT;
      end else begin
         eff_count = LEN_W'(frame_count_ff);
      end
   end

   assign last_frame = eff_count - LEN_W'(1);
   assign fill_done  = (LEN_W'(fill_pos_ff) + LEN_W'(1)) >= eff_size;
   assign rd_pos     = cmd.read_first ? '0 : seq_count_ff[POS_W-1:0];
   assign wr_addr    = ADDR_W'(write_frame_ff) * FRAME_STRIDE + ADDR_W'(fill_pos_ff);
   assign rd_addr    = ADDR_W'(read_frame_ff) * FRAME_STRIDE + ADDR_W'(rd_pos);
   assign rd_en      = cmd.read_first || cmd.read_next;

   always_comb begin
      frame_size_in  = frame_size_ff;
      frame_count_in = frame_count_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_FRAME_SIZE:  frame_size_in  = csr_wdata;
            CSR_FRAME_COUNT: frame_count_in = csr_wdata[COUNT_REG_W-1:0];
            default: begin
               frame_size_in = frame_size_ff;
            end
         endcase
      end
   end

   always_comb begin
      write_frame_in = write_frame_ff;
      fill_pos_in    = fill_pos_ff;
      if (cmd.write_byte) begin
         if (fill_done) begin
            write_frame_in = next_frame(write_frame_ff, last_frame);
            fill_pos_in    = '0;
         end else begin
            fill_pos_in = fill_pos_ff + POS_W'(1);
         end
      end
   end

   assign read_frame_in = cmd.advance_read ? next_frame(read_frame_ff, last_frame)
                                           : read_frame_ff;
   assign length_in     = cmd.read_first ? req_payload.read_length : length_ff;

   always_comb begin
      seq_count_in = seq_count_ff;
      if (cmd.read_first) begin
         seq_count_in = LEN_W'(1);
      end else if (cmd.read_next) begin
         seq_count_in = seq_count_ff + LEN_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_data_in   = rsp_data_ff;
      if (cmd.load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.out_status;
         rsp_last_in   = cmd.out_last;
         rsp_data_in   = cmd.out_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_size_ff  <= FRAME_SIZE_RESET;
         frame_count_ff <= FRAME_COUNT_RESET;
         write_frame_ff <= '0;
         read_frame_ff  <= '0;
         fill_pos_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         frame_size_ff  <= frame_size_in;
         frame_count_ff <= frame_count_in;
         write_frame_ff <= write_frame_in;
         read_frame_ff  <= read_frame_in;
         fill_pos_ff    <= fill_pos_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      length_ff     <= length_in;
      seq_count_ff  <= seq_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.write_byte) begin
         frame_mem[wr_addr] <= req_payload.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= frame_mem[rd_addr];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_payload.status   = rsp_status_ff;
   assign rsp_payload.out_byte = rsp_data_ff ? rd_data_ff : '0;
   assign rsp_payload.last     = rsp_last_ff;

   assign dp_status.out_free    = !rsp_valid_ff || !rsp_stall;
   assign dp_status.req_is_read = (req_payload.req_type == REQ_READ);
   assign dp_status.ring_empty  = (read_frame_ff == write_frame_ff);
   assign dp_status.length_bad  = (req_payload.read_length == '0) ||
                                  (req_payload.read_length > eff_size);
   assign dp_status.length_one  = (req_payload.read_length == LEN_W'(1));
   assign dp_status.read_last   = (seq_count_ff + LEN_W'(1)) == length_ff;

endmodule

// ----- tb/frame_ring_buffer_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_ring_buffer_test
// Self-checking bench for the frame ring buffer. A clocked driver presents
// queued write and read requests, and a clocked monitor checks every result
// transfer against a behavioral ring model. Stimulus runs through several
// frame size and frame count settings with random idle and stall patterns.
// ----------------------------------------------------------------------------
module frame_ring_buffer_test;
   import frb_pkg::*;

   localparam int RING_BYTES  = 64;
   localparam int RING_FRAMES = 8;
   localparam int CYCLE_LIMIT = 400000;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 csr_write_en = 1'b0;
   logic                 csr_index = CSR_FRAME_SIZE;
   logic [CSR_W-1:0]     csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_payload_type      req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_payload_type      rsp_payload;

   req_payload_type      stream_items[$];
   rsp_payload_type      ring_out_q[$];
   req_payload_type      next_item;
   rsp_payload_type      head_result;
   int unsigned          items_queued = 0;
   int unsigned          items_taken = 0;
   int unsigned          send_idle_pct = 0;
   int unsigned          stall_pct = 0;
   int unsigned          errors = 0;
   int unsigned          cycle_count = 0;

   logic [DATA_W-1:0]    ring_store[RING_FRAMES*RING_BYTES];
   bit                   byte_written[RING_FRAMES*RING_BYTES];
   logic [2:0]           wr_frame = '0;
   logic [2:0]           rd_frame = '0;
   logic [5:0]           fill_pos = '0;
   logic [LEN_W-1:0]     cfg_frame_size = FRAME_SIZE_RESET;
   logic [COUNT_REG_W-1:0] cfg_frame_count = FRAME_COUNT_RESET;

   frame_ring_buffer #(
      .MAX_FRAME_BYTES(RING_BYTES),
      .MAX_FRAMES(RING_FRAMES)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload)
   );

   function automatic int unsigned active_frame_bytes();
      if (cfg_frame_size < 1) return 1;
      if (cfg_frame_size > RING_BYTES) return RING_BYTES;
      return 32'(cfg_frame_size);
   endfunction

   function automatic int unsigned active_frames();
      if (cfg_frame_count < 2) return 2;
      if (cfg_frame_count > RING_FRAMES) return RING_FRAMES;
      return 32'(cfg_frame_count);
   endfunction

   function automatic int unsigned ring_next(input int unsigned f);
      return (f >= active_frames() - 1) ? 0 : f + 1;
   endfunction

   function automatic void queue_result(input status_type st, input logic [DATA_W-1:0] b,
                                        input logic fin);
      rsp_payload_type r;
      r.status = st;
      r.out_byte = b;
      r.last = fin;
      ring_out_q.push_back(r);
   endfunction

   // Updates the ring state for one accepted request and queues its results.
   function automatic void ring_step(input req_payload_type r);
      int unsigned span, f, p, base, len;
      span = active_frame_bytes();
      len = 32'(r.read_length);
      if (r.req_type == REQ_WRITE) begin
         f = wr_frame % RING_FRAMES;
         p = fill_pos % RING_BYTES;
         ring_store[f*RING_BYTES + p] = r.data_byte;
         byte_written[f*RING_BYTES + p] = 1'b1;
         if (p + 1 >= span) begin
            wr_frame = 3'(ring_next(f));
            fill_pos = '0;
         end else begin
            fill_pos = 6'(p + 1);
         end
         queue_result(STATUS_OK, 8'h00, 1'b1);
      end else if (rd_frame == wr_frame) begin
         queue_result(STATUS_EMPTY, 8'h00, 1'b1);
      end else if (len == 0 || len > span) begin
         queue_result(STATUS_BAD_LENGTH, 8'h00, 1'b1);
      end else begin
         base = (rd_frame % RING_FRAMES) * RING_BYTES;
         for (int unsigned i = 0; i < len; i++) begin
            queue_result(STATUS_OK, ring_store[base + i], (i + 1 == len));
         end
         rd_frame = 3'(ring_next(rd_frame % RING_FRAMES));
      end
   endfunction

   // A frame read never reaches bytes that were never stored; a request that
   // would is shortened to the stored prefix, or to zero length.
   function automatic logic [LEN_W-1:0] written_length(input logic [LEN_W-1:0] want);
      int unsigned base, n;
      if (rd_frame == wr_frame || want == 0 || want > active_frame_bytes()) return want;
      base = (rd_frame % RING_FRAMES) * RING_BYTES;
      n = 0;
      while (n < want && byte_written[base + n]) n++;
      return LEN_W'(n);
   endfunction

   function automatic void push_item(input req_kind_type kind, input logic [DATA_W-1:0] b,
                                     input logic [LEN_W-1:0] len);
      req_payload_type it;
      it.req_type = kind;
      it.data_byte = b;
      it.read_length = len;
      stream_items.push_back(it);
      items_queued++;
   endfunction

   function automatic void push_random(input int unsigned n);
      int unsigned span, pick;
      logic [LEN_W-1:0] len;
      for (int unsigned k = 0; k < n; k++) begin
         span = active_frame_bytes();
         pick = $urandom_range(99);
         len = LEN_W'($urandom_range(127));
         if (pick < 55) begin
            push_item(REQ_WRITE, DATA_W'($urandom_range(255)), len);
         end else begin
            if (pick < 70) len = LEN_W'(span);
            else if (pick < 92) len = LEN_W'($urandom_range(1, span));
            else if ($urandom_range(1) == 0) len = '0;
            else len = LEN_W'($urandom_range(span + 1, 127));
            push_item(REQ_READ, DATA_W'($urandom_range(255)), len);
         end
      end
   endfunction

   task automatic wait_idle();
      while (items_taken != items_queued || ring_out_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_W-1:0] value);
      repeat (2) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_FRAME_SIZE) cfg_frame_size = value;
      else cfg_frame_count = value[COUNT_REG_W-1:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("frame_ring_buffer_test: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            ring_step(req_payload);
            items_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (stream_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_item = stream_items.pop_front();
               if (next_item.req_type == REQ_READ) begin
                  next_item.read_length = written_length(next_item.read_length);
               end
               req_payload <= next_item;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (ring_out_q.size() == 0) begin
               $display("%0t: result with nothing expected: got status %0d byte %02h last %0b",
                        $time, rsp_payload.status, rsp_payload.out_byte, rsp_payload.last);
               errors++;
            end else begin
               head_result = ring_out_q.pop_front();
               if (rsp_payload.status !== head_result.status ||
                   rsp_payload.out_byte !== head_result.out_byte ||
                   rsp_payload.last !== head_result.last) begin
                  $display("%0t: expected %0d/%02h/%0b, got %0d/%02h/%0b",
                           $time, head_result.status, head_result.out_byte, head_result.last,
                           rsp_payload.status, rsp_payload.out_byte, rsp_payload.last);
                  errors++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reads of an empty ring, including lengths that would be rejected.
      push_item(REQ_READ, 8'hFF, 7'd5);
      push_item(REQ_READ, 8'h00, 7'd0);
      push_item(REQ_READ, 8'hA5, 7'd127);
      wait_idle();

      // Three-byte frames in a two-frame ring; the count value is masked and clamped.
      write_csr(CSR_FRAME_SIZE, 7'd3);
      write_csr(CSR_FRAME_COUNT, 7'h71);
      push_item(REQ_WRITE, 8'h00, 7'd0);
      push_item(REQ_WRITE, 8'hFF, 7'd127);
      push_item(REQ_WRITE, 8'h5A, 7'd1);
      push_item(REQ_READ, 8'h00, 7'd4);
      push_item(REQ_READ, 8'h00, 7'd0);
      push_item(REQ_READ, 8'h00, 7'd127);
      push_item(REQ_READ, 8'h00, 7'd3);
      push_item(REQ_READ, 8'h00, 7'd3);
      push_item(REQ_WRITE, 8'h11, 7'd0);
      push_item(REQ_WRITE, 8'h22, 7'd0);
      push_item(REQ_WRITE, 8'h33, 7'd0);
      // The writer laps the reader here and the pending frame is lost.
      push_item(REQ_WRITE, 8'h44, 7'd0);
      push_item(REQ_WRITE, 8'h55, 7'd0);
      push_item(REQ_WRITE, 8'h66, 7'd0);
      push_item(REQ_READ, 8'h00, 7'd2);
      push_item(REQ_WRITE, 8'h77, 7'd0);
      push_item(REQ_WRITE, 8'h88, 7'd0);
      push_item(REQ_WRITE, 8'h99, 7'd0);
      push_item(REQ_READ, 8'h00, 7'd1);
      wait_idle();

      // Full 64-byte frame with the receiver stalling.
      write_csr(CSR_FRAME_SIZE, 7'd127);
      write_csr(CSR_FRAME_COUNT, 7'h74);
      stall_pct = 59;
      repeat (64) push_item(REQ_WRITE, DATA_W'($urandom_range(255)),
                            LEN_W'($urandom_range(127)));
      push_item(REQ_READ, DATA_W'($urandom_range(255)), 7'd64);
      push_item(REQ_READ, DATA_W'($urandom_range(255)), 7'd64);
      wait_idle();

      write_csr(CSR_FRAME_SIZE, 7'd5);
      write_csr(CSR_FRAME_COUNT, 7'd8);
      stall_pct = 0;
      send_idle_pct = 59;
      push_random(12);
      wait_idle();

      write_csr(CSR_FRAME_SIZE, 7'd0);
      write_csr(CSR_FRAME_COUNT, 7'h0F);
      send_idle_pct = 38;
      stall_pct = 38;
      push_random(8);
      wait_idle();

      // Shrinking the ring moves frame indexes past the end back to frame 0.
      write_csr(CSR_FRAME_SIZE, 7'd2);
      write_csr(CSR_FRAME_COUNT, 7'd3);
      push_random(8);
      wait_idle();
      push_random(8);
      wait_idle();

      write_csr(CSR_FRAME_SIZE, 7'd1);
      write_csr(CSR_FRAME_COUNT, 7'd2);
      send_idle_pct = 0;
      stall_pct = 0;
      push_random(6);
      wait_idle();

      repeat (20) @(posedge clock);
      if (errors == 0 && ring_out_q.size() == 0) begin
         $display("frame_ring_buffer_test: done, clean");
      end else begin
         $display("frame_ring_buffer_test: done, errors");
      end
      $finish;
   end

endmodule
